### rtl/u8l1_pkg.sv
// ----------------------------------------------------------------------------
// u8l1_pkg
// Shared types and constants for the UTF-8 to Latin-1 decoder.
// ----------------------------------------------------------------------------
package u8l1_pkg;

    localparam int ByteW  = 8;
    localparam int AccumW = 31;
    localparam int RemW   = 3;

    localparam logic [ByteW-1:0] CONT_BASE = 8'h80;

    typedef struct packed {
        logic [ByteW-1:0] in_byte;
        logic             string_last;
    } in_item_t;

    typedef struct packed {
        logic [ByteW-1:0] latin1_char;
        logic             char_valid;
        logic             range_error_first;
        logic             truncated;
        logic             string_end;
    } result_t;

endpackage

### rtl/u8l1_in_stage.sv
// ----------------------------------------------------------------------------
// u8l1_in_stage
// Input register: holds one byte transaction until the decoder consumes it.
// ----------------------------------------------------------------------------
module u8l1_in_stage
    import u8l1_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_item_t in_item,
    input  logic     take,
    output logic     item_valid,
    output in_item_t item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     accept;

    assign in_stall   = valid_reg && !take;
    assign accept     = in_valid && !in_stall;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
        end
    end

endmodule

### rtl/u8l1_decode.sv
// ----------------------------------------------------------------------------
// u8l1_decode
// Sequence state and single-pass decode of one byte into an optional result.
// ----------------------------------------------------------------------------
module u8l1_decode
    import u8l1_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    input  in_item_t item,
    input  logic     out_free,
    output logic     take,
    output logic     emit,
    output result_t  result
);

    logic [RemW-1:0]   rem_reg,   rem_next;
    logic [AccumW-1:0] accum_reg, accum_next;
    logic              bad_reg,   bad_next;
    logic              err_reg,   err_next;

    logic [ByteW-1:0]  b;
    logic [RemW-1:0]   lead_len;
    logic [AccumW-1:0] lead_payload;
    logic [AccumW-1:0] cont_bits;
    logic [RemW-1:0]   rem_dec;
    logic [AccumW-1:0] value;
    logic              value_bad;
    logic              done;
    logic              char_ok;
    logic              is_low;

    assign b      = item.in_byte;
    assign is_low = (b < CONT_BASE);

    always_comb
    begin
        priority if (is_low)  lead_len = 3'd1;
        else if (!b[5])       lead_len = 3'd2;
        else if (!b[4])       lead_len = 3'd3;
        else if (!b[3])       lead_len = 3'd4;
        else if (!b[2])       lead_len = 3'd5;
        else                  lead_len = 3'd6;
    end

    always_comb
    begin
        unique case (lead_len)
            3'd2:    lead_payload = AccumW'({b & 8'h1F, 6'd0});
            3'd3:    lead_payload = AccumW'({b & 8'h0F, 12'd0});
            3'd4:    lead_payload = AccumW'({b & 8'h07, 18'd0});
            3'd5:    lead_payload = AccumW'({b & 8'h03, 24'd0});
            3'd6:    lead_payload = AccumW'({b & 8'h01, 30'd0});
            default: lead_payload = '0;
        endcase
    end

    assign rem_dec = rem_reg - 3'd1;

    always_comb
    begin
        logic [6:0] excess;
        excess = b[6:0];
        unique case (rem_dec)
            3'd0:    cont_bits = AccumW'(excess);
            3'd1:    cont_bits = AccumW'({excess, 6'd0});
            3'd2:    cont_bits = AccumW'({excess, 12'd0});
            3'd3:    cont_bits = AccumW'({excess, 18'd0});
            3'd4:    cont_bits = AccumW'({excess, 24'd0});
            default: cont_bits = '0;
        endcase
    end

    always_comb
    begin
        rem_next   = rem_reg;
        accum_next = accum_reg;
        bad_next   = bad_reg;
        err_next   = err_reg;
        value      = '0;
        value_bad  = 1'b0;
        done       = 1'b0;
        result     = '0;
        emit       = 1'b0;

        if (rem_reg == '0)
        begin
            if (lead_len == 3'd1)
            begin
                value = AccumW'(b);
                done  = 1'b1;
            end
            else
            begin
                accum_next = lead_payload;
                bad_next   = 1'b0;
                rem_next   = lead_len - 3'd1;
            end
        end
        else
        begin
            if (is_low)
            begin
                bad_next = 1'b1;
            end
            else
            begin
                accum_next = accum_reg | cont_bits;
            end
            rem_next = rem_dec;
            if (rem_dec == '0)
            begin
                value      = accum_next;
                value_bad  = bad_next;
                done       = 1'b1;
                accum_next = '0;
                bad_next   = 1'b0;
            end
        end

        char_ok = !value_bad && (value[AccumW-1:ByteW] == '0);

        if (done)
        begin
            if (char_ok)
            begin
                result.latin1_char = value[ByteW-1:0];
                result.char_valid  = 1'b1;
                emit               = 1'b1;
            end
            else if (!err_reg)
            begin
                err_next                 = 1'b1;
                result.range_error_first = 1'b1;
                emit                     = 1'b1;
            end
        end

        if (item.string_last)
        begin
            result.truncated  = (rem_next != '0);
            result.string_end = 1'b1;
            emit              = 1'b1;
            rem_next          = '0;
            accum_next        = '0;
            bad_next          = 1'b0;
            err_next          = 1'b0;
        end
    end

    assign take = item_valid && (!emit || out_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg   <= '0;
            accum_reg <= '0;
            bad_reg   <= 1'b0;
            err_reg   <= 1'b0;
        end
        else if (take)
        begin
            rem_reg   <= rem_next;
            accum_reg <= accum_next;
            bad_reg   <= bad_next;
            err_reg   <= err_next;
        end
    end

endmodule

### rtl/u8l1_out_stage.sv
// ----------------------------------------------------------------------------
// u8l1_out_stage
// Result register: holds one result transaction until the receiver takes it.
// ----------------------------------------------------------------------------
module u8l1_out_stage
    import u8l1_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t result,
    output logic    out_free,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t out_result
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign out_free   = !valid_reg || !out_stall;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            valid_next = valid_reg;
        end
        else
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

endmodule

### rtl/utf8_to_latin1_decoder.sv
// ----------------------------------------------------------------------------
// utf8_to_latin1_decoder
// Streams UTF-8 bytes in and Latin-1 characters with status flags out.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall with in_byte and string_last. One byte per
// transaction; string_last marks the final byte of a string.
// Output channel: out_valid/out_stall with latin1_char, char_valid,
// range_error_first, truncated and string_end. A byte yields zero or one
// result; the final byte of a string always yields one.
// Path: a byte is held in the input register, decoded, and its result is
// presented from the result register.
// Throughput: one byte per cycle while the output is not stalled, set by the
// single decode pass between the input register and the result register.
// Reset clears the sequence state, the per-string error flag and the valid
// flags of both pipeline registers. While the receiver stalls a waiting
// result, a byte that produces no result still drains; a byte that produces
// one waits in the input register, and in_stall rises once it is occupied.
// ----------------------------------------------------------------------------
module utf8_to_latin1_decoder
    import u8l1_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [ByteW-1:0] in_byte,
    input  logic             string_last,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [ByteW-1:0] latin1_char,
    output logic             char_valid,
    output logic             range_error_first,
    output logic             truncated,
    output logic             string_end
);

    in_item_t in_item;
    in_item_t item;
    logic     item_valid;
    logic     take;
    logic     emit;
    logic     out_free;
    result_t  result;
    result_t  out_result;

    assign in_item.in_byte     = in_byte;
    assign in_item.string_last = string_last;

    u8l1_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    u8l1_decode u_decode
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .out_free   (out_free),
        .take       (take),
        .emit       (emit),
        .result     (result)
    );

    u8l1_out_stage u_out_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (take && emit),
        .result     (result),
        .out_free   (out_free),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_result (out_result)
    );

    assign latin1_char       = out_result.latin1_char;
    assign char_valid        = out_result.char_valid;
    assign range_error_first = out_result.range_error_first;
    assign truncated         = out_result.truncated;
    assign string_end        = out_result.string_end;

    a_char_xor_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(char_valid && range_error_first))
        else $error("char_valid and range_error_first both set");

    a_trunc_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && truncated |-> string_end)
        else $error("truncated without string_end");

    a_no_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (char_valid || range_error_first || string_end))
        else $error("result transaction carries nothing");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> item_valid && emit && !out_free)
        else $error("input stalled while decode could proceed");

endmodule
